>>> src/tbeg_pkg.sv
// ----------------------------------------------------------------------------
// Two-bump envelope generator package
// Shared widths, register indexes, reset values and divider request and response types.
// ----------------------------------------------------------------------------
package tbeg_pkg;

    // Sample counter width and saturation value
    localparam int COUNT_BITS = 24;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Field widths
    localparam int GATE_W     = 2;
    localparam int LEVEL_W    = 16;
    localparam int TIME_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SMOOTH_W   = 32;

    // Compare width wide enough for attack plus decay and for the counter
    localparam int CMP_W = (COUNT_BITS > TIME_W + 1) ? COUNT_BITS : TIME_W + 1;

    // Serial divider: quotient never exceeds 17 bits, divisor is a region length
    localparam int QUO_W      = LEVEL_W + 1;
    localparam int DIVIDEND_W = QUO_W + TIME_W;
    localparam int DIV_CNT_W  = $clog2(QUO_W);

    // Shared multiplier operand widths
    localparam int MUL_A_W = SMOOTH_W;
    localparam int MUL_B_W = LEVEL_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [LEVEL_W-1:0] UNITY = 16'd32768;

    // Gate codes
    localparam logic [GATE_W-1:0] GATE_IDLE = 2'd0;
    localparam logic [GATE_W-1:0] GATE_OFF  = 2'd1;
    localparam logic [GATE_W-1:0] GATE_ON   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ON_BUMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_ATTACK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_DECAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_BUMP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_ATTACK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DECAY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW       = 3'd7;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_ON_BUMP    = 16'd32768;
    localparam logic [TIME_W-1:0]  RST_ON_ATTACK  = 24'd480;
    localparam logic [TIME_W-1:0]  RST_ON_DECAY   = 24'd2400;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN    = 16'd0;
    localparam logic [LEVEL_W-1:0] RST_OFF_BUMP   = 16'd32768;
    localparam logic [TIME_W-1:0]  RST_OFF_ATTACK = 24'd2400;
    localparam logic [TIME_W-1:0]  RST_OFF_DECAY  = 24'd2400;
    localparam logic [LEVEL_W-1:0] RST_SLEW       = 16'd58982;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [TIME_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> src/tbeg_gate_if.sv
// ----------------------------------------------------------------------------
// Gate request channel
// Valid/ready channel carrying one gate level per sample tick.
// ----------------------------------------------------------------------------
interface tbeg_gate_if;
    logic                      valid;
    logic                      ready;
    logic [tbeg_pkg::GATE_W-1:0] gate_level;

    modport source (output valid, output gate_level, input ready);
    modport sink   (input valid, input gate_level, output ready);
endinterface

>>> src/tbeg_env_if.sv
// ----------------------------------------------------------------------------
// Envelope result channel
// Valid/ready channel carrying one smoothed envelope value per tick.
// ----------------------------------------------------------------------------
interface tbeg_env_if;
    logic                         valid;
    logic                         ready;
    logic [tbeg_pkg::LEVEL_W-1:0] envelope_value;

    modport source (output valid, output envelope_value, input ready);
    modport sink   (input valid, input envelope_value, output ready);
endinterface

>>> src/tbeg_divider.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle; the quotient is known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
module tbeg_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbeg_pkg::t_div_req i_req,
    output tbeg_pkg::t_div_rsp o_rsp
);
    import tbeg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]    r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [TIME_W-1:0]    r_div;

    logic [TIME_W:0]      trial;
    logic                 q_bit;

    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign q_bit = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Payload: partial remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[DIVIDEND_W-1:QUO_W];
            r_quo <= i_req.dividend[QUO_W-1:0];
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? TIME_W'(trial - {1'b0, r_div}) : trial[TIME_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], q_bit};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> src/two_bump_envelope_generator.sv
// ----------------------------------------------------------------------------
// Two-bump envelope generator
// Per-sample envelope with note-on and release bumps and a one-pole slew.
// ----------------------------------------------------------------------------
// Each gate request is one sample tick and yields exactly one envelope value.
// A non-idle tick in a ramp region steps through select, multiply, divider
// start, divider wait (17 quotient bits, one per cycle) and the filter states
// before its result is loaded into the output register; on the flat sustain
// or closed regions it skips the multiply and divide states, and an idle tick
// goes from select straight to done. The gate channel is ready only while the
// sequencer is idle, and the next request may be accepted while the previous
// result still waits in the output register. Configuration writes take effect
// at once and should be issued only between ticks. All products come from one
// shared 32x17 multiplier and all quotients from the serial divider.
// ----------------------------------------------------------------------------
module two_bump_envelope_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tbeg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbeg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    tbeg_gate_if.sink                          i_gate,
    tbeg_env_if.source                         o_env
);
    import tbeg_pkg::*;

    // Sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SEL   = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DSTRT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FLT1  = 3'd5;
    localparam logic [2:0] ST_FLT2  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    // Configuration registers
    logic [LEVEL_W-1:0] r_on_bump, r_sustain, r_off_bump, r_slew;
    logic [TIME_W-1:0]  r_on_attack, r_on_decay, r_off_attack, r_off_decay;

    // Control state
    logic [2:0]            r_state;
    logic [COUNT_BITS-1:0] r_count;
    logic [GATE_W-1:0]     r_prev_gate;
    logic [GATE_W-1:0]     r_gate;
    logic                  r_out_valid;

    // Datapath registers
    logic [SMOOTH_W-1:0]   r_smooth;
    logic [MUL_B_W-1:0]    r_mcand;
    logic [TIME_W-1:0]     r_mop;
    logic [TIME_W-1:0]     r_divisor;
    logic [LEVEL_W-1:0]    r_base;
    logic [LEVEL_W-1:0]    r_target;
    logic [MUL_P_W-1:0]    r_acc;
    logic [LEVEL_W-1:0]    r_out_value;

    logic [COUNT_BITS-1:0] n_count;
    logic                  accept;

    // Region decode
    logic                  gate_on;
    logic [TIME_W-1:0]     sel_attack, sel_decay;
    logic [LEVEL_W-1:0]    sel_bump;
    logic [CMP_W-1:0]      n_ext, a_ext, ad_sum, remain;
    logic [MUL_B_W-1:0]    peak;

    // Shared multiplier
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]    mul_p;

    logic [MUL_P_W-1:0]    filt_sum;
    logic [LEVEL_W+1:0]    tgt_sum;
    logic [SMOOTH_W:0]     rounded;

    t_div_req div_req;
    t_div_rsp div_rsp;

    assign accept       = i_gate.valid && i_gate.ready;
    assign i_gate.ready = (r_state == ST_IDLE);

    // Clear the counter on an on/not-on change, then advance it unless idle or saturated
    always_comb begin
        n_count = (i_gate.gate_level[1] != r_prev_gate[1]) ? '0 : r_count;
        if (i_gate.gate_level != GATE_IDLE && n_count != COUNT_MAX) begin
            n_count = n_count + 1'b1;
        end
    end

    // Pick the on or release region set and locate the counter within it
    assign gate_on    = r_gate[1];
    assign sel_attack = gate_on ? r_on_attack : r_off_attack;
    assign sel_decay  = gate_on ? r_on_decay  : r_off_decay;
    assign sel_bump   = gate_on ? r_on_bump   : r_off_bump;
    assign n_ext      = CMP_W'(r_count);
    assign a_ext      = CMP_W'(sel_attack);
    assign ad_sum     = a_ext + CMP_W'(sel_decay);
    assign remain     = ad_sum - n_ext;
    assign peak       = {1'b0, r_sustain} + {1'b0, sel_bump};

    // Operand select for the one multiplier
    always_comb begin
        case (r_state)
            ST_MUL: begin
                mul_a = MUL_A_W'(r_mop);
                mul_b = r_mcand;
            end
            ST_FLT1: begin
                mul_a = r_smooth;
                mul_b = {1'b0, r_slew};
            end
            ST_FLT2: begin
                mul_a = MUL_A_W'(r_target);
                mul_b = MUL_B_W'(18'h10000 - {2'b0, r_slew});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign filt_sum = r_acc + {mul_p[MUL_P_W-17:0], 16'b0};
    assign tgt_sum  = {2'b0, r_base} + {1'b0, div_rsp.quotient};
    assign rounded  = {1'b0, r_smooth} + (SMOOTH_W+1)'(32768);

    assign div_req.start    = (r_state == ST_DSTRT);
    assign div_req.dividend = r_acc[DIVIDEND_W-1:0];
    assign div_req.divisor  = r_divisor;

    tbeg_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration writes: mask to the register width; every index maps to a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_bump    <= RST_ON_BUMP;
            r_on_attack  <= RST_ON_ATTACK;
            r_on_decay   <= RST_ON_DECAY;
            r_sustain    <= RST_SUSTAIN;
            r_off_bump   <= RST_OFF_BUMP;
            r_off_attack <= RST_OFF_ATTACK;
            r_off_decay  <= RST_OFF_DECAY;
            r_slew       <= RST_SLEW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ON_BUMP:    r_on_bump    <= i_cfg_data[LEVEL_W-1:0];
                REG_ON_ATTACK:  r_on_attack  <= i_cfg_data[TIME_W-1:0];
                REG_ON_DECAY:   r_on_decay   <= i_cfg_data[TIME_W-1:0];
                REG_SUSTAIN:    r_sustain    <= i_cfg_data[LEVEL_W-1:0];
                REG_OFF_BUMP:   r_off_bump   <= i_cfg_data[LEVEL_W-1:0];
                REG_OFF_ATTACK: r_off_attack <= i_cfg_data[TIME_W-1:0];
                REG_OFF_DECAY:  r_off_decay  <= i_cfg_data[TIME_W-1:0];
                REG_SLEW:       r_slew       <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_prev_gate <= GATE_IDLE;
            r_gate      <= GATE_IDLE;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a fresh result when the output register frees up, else
            // drop the current one once the sink has taken it
            if (r_state == ST_DONE && (!r_out_valid || o_env.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_env.valid && o_env.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_count     <= n_count;
                        r_prev_gate <= i_gate.gate_level;
                        r_gate      <= i_gate.gate_level;
                        r_state     <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    if (r_gate == GATE_IDLE) begin
                        // Idle forces the filter closed and the output to zero
                        r_smooth <= '0;
                        r_state  <= ST_DONE;
                    end else if (n_ext < a_ext || n_ext < ad_sum) begin
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_FLT1;
                    end
                end
                ST_MUL:   r_state <= ST_DSTRT;
                ST_DSTRT: r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= ST_FLT1;
                    end
                end
                ST_FLT1: r_state <= ST_FLT2;
                ST_FLT2: begin
                    r_smooth <= filt_sum[SMOOTH_W+15:16];
                    r_state  <= ST_DONE;
                end
                ST_DONE: begin
                    // Hold until the output register is free
                    if (!r_out_valid || o_env.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SEL: begin
                if (n_ext < a_ext) begin
                    // Rise: peak-from-zero when on, sustain-to-peak on release
                    r_mcand   <= gate_on ? peak : {1'b0, sel_bump};
                    r_mop     <= n_ext[TIME_W-1:0];
                    r_divisor <= sel_attack;
                    r_base    <= gate_on ? '0 : r_sustain;
                end else if (n_ext < ad_sum) begin
                    // Fall: bump back to sustain when on, peak to zero on release
                    r_mcand   <= gate_on ? {1'b0, sel_bump} : peak;
                    r_mop     <= remain[TIME_W-1:0];
                    r_divisor <= sel_decay;
                    r_base    <= gate_on ? r_sustain : '0;
                end else begin
                    r_target <= (gate_on && r_sustain <= UNITY) ? r_sustain
                              : (gate_on ? UNITY : '0);
                end
            end
            ST_MUL:  r_acc <= mul_p;
            ST_DIV: begin
                if (div_rsp.done) begin
                    r_target <= (tgt_sum > {2'b0, UNITY}) ? UNITY : tgt_sum[LEVEL_W-1:0];
                end
            end
            ST_FLT1: r_acc <= mul_p;
            ST_DONE: begin
                if (!r_out_valid || o_env.ready) begin
                    r_out_value <= rounded[SMOOTH_W-1:16];
                end
            end
            default: ;
        endcase
    end

    assign o_env.valid          = r_out_valid;
    assign o_env.envelope_value = r_out_value;

`ifndef ASSERT_OFF
    // The slew filter is a convex mix of values no larger than unity
    a_smooth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_smooth <= 32'h8000_0000)
        else $error("filter state above unity");

    // A presented envelope never exceeds unity
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_env.valid |-> o_env.envelope_value <= UNITY)
        else $error("envelope above unity");

    // A non-idle tick always leaves a non-zero counter
    a_count_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_gate.gate_level != GATE_IDLE) |=> r_count != '0)
        else $error("sample counter not advanced");

    // The divider only works and reports completion while the sequencer waits
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_rsp.busy || div_rsp.done) |-> r_state == ST_DIV)
        else $error("divider active outside its wait state");
`endif

endmodule
